// ===== hdl/rwt_pkg.sv =====
// shared types, constants and helpers for the retransmit wait table
// no dependencies; used by every module of the block by scoped names
package rwt_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int TIMER_BITS  = 16;
   localparam int MAX_RESULTS = 8;

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int REP_W  = $clog2(MAX_RESULTS + 1);

   localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_LOOKUP = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ACT_ADDED     = 4'd0,
      ACT_FULL      = 4'd1,
      ACT_BAD_LEN   = 4'd2,
      ACT_REMOVED   = 4'd3,
      ACT_NOT_FOUND = 4'd4,
      ACT_RESEND    = 4'd5,
      ACT_REJECTED  = 4'd6,
      ACT_IDLE      = 4'd7,
      ACT_PRESENT   = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESULT,
      ST_ADD,
      ST_FIND,
      ST_COUNT,
      ST_APPLY,
      ST_QUIET
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [7:0]            packet_id;
      logic [15:0]           buffer;
      logic [15:0]           length;
      logic [7:0]            retries;
      logic [TIMER_BITS-1:0] period;
      logic [TIMER_BITS-1:0] countdown;
   } slot_type;

   typedef struct packed {
      logic     free;
      logic     match;
      logic     expire;
      logic     reject;
      slot_type next;
   } eval_type;

   typedef struct packed {
      action_type  action;
      logic [2:0]  slot;
      logic [7:0]  packet_id;
      logic [15:0] buffer;
      logic [15:0] length;
      logic [7:0]  retries;
      logic [3:0]  occupancy;
      logic        last;
   } result_type;

   // timeout clamped to the countdown range
   function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [15:0] t);
      logic [63:0] wide;
      wide = {48'd0, t};
      if (wide > TIMER_MAX) begin
         return {TIMER_BITS{1'b1}};
      end
      return TIMER_BITS'(wide);
   endfunction

endpackage

// ===== hdl/rwt_slot_eval.sv =====
// slot evaluator shared by every scan: id compare, countdown and retry checks
// depends on rwt_pkg
module rwt_slot_eval (
   input  rwt_pkg::slot_type entry,
   input  logic [7:0]        packet_id,
   input  logic [7:0]        retry_limit,
   output rwt_pkg::eval_type result
);

   logic expire;
   logic reject;

   assign expire = entry.valid && (entry.countdown <= rwt_pkg::TIMER_BITS'(1));
   assign reject = expire && (entry.retries >= retry_limit);

   always_comb begin
      result.free   = !entry.valid;
      result.match  = entry.valid && (packet_id != 8'd0) && (entry.packet_id == packet_id);
      result.expire = expire;
      result.reject = reject;
      result.next   = entry;
      if (entry.valid) begin
         if (!expire) begin
            result.next.countdown = entry.countdown - rwt_pkg::TIMER_BITS'(1);
         end else if (reject) begin
            result.next.valid = 1'b0;
         end else begin
            if (entry.retries != 8'hff) begin
               result.next.retries = entry.retries + 8'd1;
            end
            result.next.countdown = entry.period;
         end
      end
   end

endmodule

// ===== hdl/rwt_slot_table.sv =====
// slot storage: one read port and one write port, valid bits cleared at reset
// depends on rwt_pkg
module rwt_slot_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rwt_pkg::SLOT_W-1:0]  rd_idx,
   output rwt_pkg::slot_type           rd_data,
   input  logic                        wr_en,
   input  logic [rwt_pkg::SLOT_W-1:0]  wr_idx,
   input  rwt_pkg::slot_type           wr_data
);

   logic [rwt_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [rwt_pkg::TABLE_DEPTH-1:0] valid_in;
   rwt_pkg::slot_type               entry_ff [rwt_pkg::TABLE_DEPTH];

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = wr_data.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_idx] <= wr_data;
      end
   end

   always_comb begin
      rd_data       = entry_ff[rd_idx];
      rd_data.valid = valid_ff[rd_idx];
   end

endmodule

// ===== hdl/retransmit_wait_table.sv =====
// retransmit wait table: up to eight packets waiting for acknowledgement.
// req channel: one item is an add, remove, tick or lookup; accepted when
// req_valid is high and req_stall is low. req_stall is high while an item
// is being worked on, so one item is in the block at a time.
// rsp channel: result items, taken when rsp_valid is high and rsp_stall low.
// an add, remove or lookup gives one result, a tick gives one result per
// expired slot (at most eight) or a single idle result; rsp_last marks the
// final result of an item. the output register lets the next item enter
// while the last result still waits to be taken.
// one slot evaluator scans the table one slot per cycle: add, remove and
// lookup stop at the first free or matching slot or at the last slot, a
// tick makes a count pass and then an update pass over all slots.
// a stalled receiver holds the scan at the slot that has a result to give.
// csr channel: retry_limit, always ready; the user must write it only between items, the block does not enforce this.
// reset (synchronous) empties the table and sets retry_limit to 3.
// depends on rwt_pkg, rwt_slot_eval, rwt_slot_table
module retransmit_wait_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_packet_id,
   input  logic [15:0] req_buffer_handle,
   input  logic [15:0] req_length,
   input  logic [15:0] req_timeout,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_action,
   output logic [2:0]  rsp_slot,
   output logic [7:0]  rsp_packet_id_out,
   output logic [15:0] rsp_buffer_out,
   output logic [15:0] rsp_length_out,
   output logic [7:0]  rsp_retries_out,
   output logic [3:0]  rsp_occupancy,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_retry_limit
);

   rwt_pkg::state_type state_ff, state_in;

   logic [7:0]                  retry_limit_ff, retry_limit_in;
   rwt_pkg::kind_type           kind_ff, kind_in;
   logic [7:0]                  id_ff, id_in;
   logic [15:0]                 buf_ff, buf_in;
   logic [15:0]                 len_ff, len_in;
   logic [rwt_pkg::TIMER_BITS-1:0] tmo_ff, tmo_in;
   logic [rwt_pkg::SLOT_W-1:0]  idx_ff, idx_in;
   logic [rwt_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [rwt_pkg::CNT_W-1:0]   exp_cnt_ff, exp_cnt_in;
   logic [rwt_pkg::CNT_W-1:0]   rej_cnt_ff, rej_cnt_in;
   logic [rwt_pkg::REP_W-1:0]   rep_ff, rep_in;
   logic [rwt_pkg::REP_W-1:0]   rep_total_ff, rep_total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rwt_pkg::result_type         rsp_ff, rsp_in;

   rwt_pkg::slot_type           rd_entry;
   rwt_pkg::eval_type           ev;
   logic                        wr_en;
   rwt_pkg::slot_type           wr_entry;

   logic                        req_fire;
   logic                        out_free;
   logic                        at_end;
   logic                        report;
   logic                        can_go;
   logic                        emit;
   rwt_pkg::result_type         res;

   rwt_slot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx_ff),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_idx  (idx_ff),
      .wr_data (wr_entry)
   );

   rwt_slot_eval u_eval (
      .entry       (rd_entry),
      .packet_id   (id_ff),
      .retry_limit (retry_limit_ff),
      .result      (ev)
   );

   assign req_stall = (state_ff != rwt_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign at_end    = (idx_ff == rwt_pkg::SLOT_W'(rwt_pkg::TABLE_DEPTH - 1));
   assign report    = ev.expire && (rep_ff < rep_total_ff);
   assign can_go    = !report || out_free;
   assign csr_ready = 1'b1;

   assign retry_limit_in = (csr_valid && csr_ready) ? csr_retry_limit : retry_limit_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rwt_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (rwt_pkg::kind_type'(req_kind))
                  rwt_pkg::KIND_ADD: begin
                     state_in = (req_length == 16'd0) ? rwt_pkg::ST_RESULT : rwt_pkg::ST_ADD;
                  end
                  rwt_pkg::KIND_TICK: begin
                     state_in = rwt_pkg::ST_COUNT;
                  end
                  default: begin
                     state_in = (req_packet_id == 8'd0) ? rwt_pkg::ST_RESULT
                                                        : rwt_pkg::ST_FIND;
                  end
               endcase
            end
         end
         rwt_pkg::ST_RESULT, rwt_pkg::ST_QUIET: begin
            if (out_free) begin
               state_in = rwt_pkg::ST_IDLE;
            end
         end
         rwt_pkg::ST_ADD: begin
            if ((ev.free || at_end) && out_free) begin
               state_in = rwt_pkg::ST_IDLE;
            end
         end
         rwt_pkg::ST_FIND: begin
            if ((ev.match || at_end) && out_free) begin
               state_in = rwt_pkg::ST_IDLE;
            end
         end
         rwt_pkg::ST_COUNT: begin
            if (at_end) begin
               state_in = rwt_pkg::ST_APPLY;
            end
         end
         rwt_pkg::ST_APPLY: begin
            if (can_go && at_end) begin
               state_in = (exp_cnt_ff == '0) ? rwt_pkg::ST_QUIET : rwt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rwt_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      kind_in      = kind_ff;
      id_in        = id_ff;
      buf_in       = buf_ff;
      len_in       = len_ff;
      tmo_in       = tmo_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      exp_cnt_in   = exp_cnt_ff;
      rej_cnt_in   = rej_cnt_ff;
      rep_in       = rep_ff;
      rep_total_in = rep_total_ff;
      wr_en        = 1'b0;
      wr_entry     = rd_entry;
      emit         = 1'b0;
      res          = '0;
      res.action   = rwt_pkg::ACT_IDLE;
      res.occupancy = 4'(count_ff);
      res.last     = 1'b1;
      case (state_ff)
         rwt_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in    = rwt_pkg::kind_type'(req_kind);
               id_in      = req_packet_id;
               buf_in     = req_buffer_handle;
               len_in     = req_length;
               tmo_in     = rwt_pkg::sat_timer(req_timeout);
               idx_in     = '0;
               exp_cnt_in = '0;
               rej_cnt_in = '0;
               rep_in     = '0;
            end
         end
         rwt_pkg::ST_RESULT: begin
            emit          = out_free;
            res.action    = (kind_ff == rwt_pkg::KIND_ADD) ? rwt_pkg::ACT_BAD_LEN
                                                           : rwt_pkg::ACT_NOT_FOUND;
            res.packet_id = id_ff;
         end
         rwt_pkg::ST_ADD: begin
            res.packet_id = id_ff;
            if (ev.free) begin
               emit = out_free;
               if (out_free) begin
                  wr_en              = 1'b1;
                  wr_entry.valid     = 1'b1;
                  wr_entry.packet_id = id_ff;
                  wr_entry.buffer    = buf_ff;
                  wr_entry.length    = len_ff;
                  wr_entry.retries   = 8'd0;
                  wr_entry.period    = tmo_ff;
                  wr_entry.countdown = tmo_ff;
                  count_in           = count_ff + rwt_pkg::CNT_W'(1);
               end
               res.action    = rwt_pkg::ACT_ADDED;
               res.slot      = 3'(idx_ff);
               res.occupancy = 4'(count_ff + rwt_pkg::CNT_W'(1));
            end else if (at_end) begin
               emit       = out_free;
               res.action = rwt_pkg::ACT_FULL;
            end else begin
               idx_in = idx_ff + rwt_pkg::SLOT_W'(1);
            end
         end
         rwt_pkg::ST_FIND: begin
            res.packet_id = id_ff;
            if (ev.match) begin
               emit        = out_free;
               res.slot    = 3'(idx_ff);
               res.retries = rd_entry.retries;
               if (kind_ff == rwt_pkg::KIND_REMOVE) begin
                  res.action     = rwt_pkg::ACT_REMOVED;
                  res.occupancy  = 4'(count_ff - rwt_pkg::CNT_W'(1));
                  wr_entry.valid = 1'b0;
                  if (out_free) begin
                     wr_en    = 1'b1;
                     count_in = count_ff - rwt_pkg::CNT_W'(1);
                  end
               end else begin
                  res.action = rwt_pkg::ACT_PRESENT;
               end
            end else if (at_end) begin
               emit       = out_free;
               res.action = rwt_pkg::ACT_NOT_FOUND;
            end else begin
               idx_in = idx_ff + rwt_pkg::SLOT_W'(1);
            end
         end
         rwt_pkg::ST_COUNT: begin
            // first pass: how many expire and how many leave, so every
            // result of the tick can carry the final occupancy
            exp_cnt_in = exp_cnt_ff + rwt_pkg::CNT_W'(ev.expire);
            rej_cnt_in = rej_cnt_ff + rwt_pkg::CNT_W'(ev.reject);
            if (at_end) begin
               count_in = count_ff - rej_cnt_in;
               if (int'(exp_cnt_in) > rwt_pkg::MAX_RESULTS) begin
                  rep_total_in = rwt_pkg::REP_W'(rwt_pkg::MAX_RESULTS);
               end else begin
                  rep_total_in = rwt_pkg::REP_W'(exp_cnt_in);
               end
               idx_in = '0;
            end else begin
               idx_in = idx_ff + rwt_pkg::SLOT_W'(1);
            end
         end
         rwt_pkg::ST_APPLY: begin
            wr_entry      = ev.next;
            res.slot      = 3'(idx_ff);
            res.packet_id = rd_entry.packet_id;
            res.last      = (rwt_pkg::REP_W'(rep_ff + rwt_pkg::REP_W'(1)) == rep_total_ff);
            if (ev.reject) begin
               res.action  = rwt_pkg::ACT_REJECTED;
               res.retries = rd_entry.retries;
            end else begin
               res.action  = rwt_pkg::ACT_RESEND;
               res.buffer  = rd_entry.buffer;
               res.length  = rd_entry.length;
               res.retries = ev.next.retries;
            end
            if (can_go) begin
               wr_en = rd_entry.valid;
               emit  = report;
               if (report) begin
                  rep_in = rep_ff + rwt_pkg::REP_W'(1);
               end
               if (!at_end) begin
                  idx_in = idx_ff + rwt_pkg::SLOT_W'(1);
               end
            end
         end
         rwt_pkg::ST_QUIET: begin
            emit = out_free;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rwt_pkg::ST_IDLE;
         retry_limit_ff <= 8'd3;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         idx_ff         <= '0;
         exp_cnt_ff     <= '0;
         rej_cnt_ff     <= '0;
         rep_ff         <= '0;
         rep_total_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         retry_limit_ff <= retry_limit_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         idx_ff         <= idx_in;
         exp_cnt_ff     <= exp_cnt_in;
         rej_cnt_ff     <= rej_cnt_in;
         rep_ff         <= rep_in;
         rep_total_ff   <= rep_total_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      id_ff   <= id_in;
      buf_ff  <= buf_in;
      len_ff  <= len_in;
      tmo_ff  <= tmo_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_slot          = rsp_ff.slot;
   assign rsp_packet_id_out = rsp_ff.packet_id;
   assign rsp_buffer_out    = rsp_ff.buffer;
   assign rsp_length_out    = rsp_ff.length;
   assign rsp_retries_out   = rsp_ff.retries;
   assign rsp_occupancy     = rsp_ff.occupancy;
   assign rsp_last          = rsp_ff.last;

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != rwt_pkg::ST_IDLE))
      else $error("accepted item did not start work");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rwt_pkg::CNT_W'(rwt_pkg::TABLE_DEPTH))
      else $error("occupancy beyond table depth");

   a_reports_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rwt_pkg::ST_APPLY) |-> (rep_ff <= rep_total_ff))
      else $error("more tick results than expiries");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !emit)
      else $error("result register overwritten while stalled");
`endif

endmodule
